// File: sv/fixed_point_alu_top_assert.svh
`ifndef FIXED_POINT_ALU_TOP_ASSERT_SVH
`define FIXED_POINT_ALU_TOP_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define FPA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Condition that must never be seen outside reset.
`define FPA_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: sv/fpa_pkg.sv
package fpa_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int IN_TDATA_W = 72;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [3:0] {
		ACT_ADD      = 4'd0,
		ACT_SUB      = 4'd1,
		ACT_MUL      = 4'd2,
		ACT_DIV      = 4'd3,
		ACT_CMP      = 4'd4,
		ACT_MIN      = 4'd5,
		ACT_MAX      = 4'd6,
		ACT_INC      = 4'd7,
		ACT_DEC      = 4'd8,
		ACT_TO_INT   = 4'd9,
		ACT_FROM_INT = 4'd10
	} action_t;

	// One classified operation waiting for the back end.
	typedef struct packed {
		logic [3:0]               action;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
		logic                     less;
		logic                     equal;
		logic                     greater;
		logic                     div_zero;
	} item_t;

	function automatic logic [DATA_W-1:0] magnitude(input logic signed [DATA_W-1:0] x);
		magnitude = x[DATA_W-1] ? (~x + 1'b1) : x;
	endfunction

endpackage

// File: sv/fpa_front.sv
module fpa_front
	import fpa_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic [IN_TDATA_W-1:0] tdata,
	output item_t                 item
);

	localparam int SAT_W = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
	localparam int SH = DATA_W - SAT_W;

	logic [DATA_W-1:0] raw_a, raw_b, shl_a, shl_b;
	logic signed [DATA_W-1:0] ext_a, ext_b;

	// Operands are taken at the saturation width and sign extended.
	always_comb begin
		raw_a = tdata[4 +: DATA_W];
		raw_b = tdata[4 + DATA_W +: DATA_W];
		shl_a = raw_a << SH;
		shl_b = raw_b << SH;
		ext_a = $signed(shl_a) >>> SH;
		ext_b = $signed(shl_b) >>> SH;
		item.action = tdata[3:0];
		item.operand_a = ext_a;
		item.operand_b = ext_b;
		item.less = ext_a < ext_b;
		item.equal = ext_a == ext_b;
		item.greater = ext_a > ext_b;
		item.div_zero = (tdata[3:0] == ACT_DIV) && (ext_b == '0);
	end

endmodule

// File: sv/fpa_queue.sv
module fpa_queue
	import fpa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;

	assign full = cnt_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/fpa_div.sv
module fpa_div
	import fpa_pkg::*;
#(
	parameter int NUM_W = DATA_W + FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DATA_W-1:0] den,
	output logic              busy,
	output logic              done,
	output logic [NUM_W-1:0]  quo,
	output logic [DATA_W:0]   rem,
	output logic [DATA_W-1:0] den_out
);

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic [NUM_W-1:0]  quo_q;
	logic [DATA_W:0]   rem_q, trial;
	logic [DATA_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q, ge;

	// Restoring division, one quotient bit per cycle.
	always_comb begin
		trial = {rem_q[DATA_W-1:0], quo_q[NUM_W-1]};
		ge = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, den_q} : trial;
			quo_q <= (quo_q << 1) | NUM_W'(ge);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo = quo_q;
	assign rem = rem_q;
	assign den_out = den_q;

endmodule

// File: sv/fpa_back.sv
`include "fixed_point_alu_top_assert.svh"

module fpa_back
	import fpa_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  item_t                  head_item,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int SAT_W = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
	localparam int NUM_W = DATA_W + FRAC_BITS;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
	localparam logic [63:0] HALF = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
	localparam logic signed [63:0] TRUNC_ADJ = (64'sd1 <<< FRAC_BITS) - 64'sd1;

	item_t        item_s1;
	logic [63:0]  prod_s1;
	logic         v_s1, v_s2;
	logic [DATA_W-1:0] result_s2;
	logic         less_s2, equal_s2, greater_s2, ovf_s2, dz_s2;

	logic              div_start, div_busy, div_done;
	logic [NUM_W-1:0]  div_quo;
	logic [DATA_W:0]   div_rem;
	logic [DATA_W-1:0] div_den;
	logic              exec_ok, go_s1, load_s1;
	logic signed [63:0] wide, sat_val;
	logic [63:0]  mmag, qmag;
	logic         sat_en, ovf, neg;

	assign exec_ok = !(item_s1.action == ACT_DIV && !item_s1.div_zero) || div_done;
	assign go_s1 = v_s1 && exec_ok && (!v_s2 || m_tready);
	assign load_s1 = head_valid && (!v_s1 || go_s1);
	assign pop = load_s1;
	assign div_start = load_s1 && head_item.action == ACT_DIV && !head_item.div_zero;

	fpa_div #(.NUM_W(NUM_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(NUM_W'(magnitude(head_item.operand_a)) << FRAC_BITS),
		.den(magnitude(head_item.operand_b)),
		.busy(div_busy), .done(div_done), .quo(div_quo), .rem(div_rem), .den_out(div_den)
	);

	always_comb begin
		neg = item_s1.operand_a[DATA_W-1] ^ item_s1.operand_b[DATA_W-1];
		mmag = (prod_s1 + HALF) >> FRAC_BITS;
		qmag = 64'(div_quo) + 64'(({div_rem, 1'b0}) >= {2'b00, div_den});
		wide = '0;
		sat_en = 1'b1;
		case (action_t'(item_s1.action))
			ACT_ADD:      wide = 64'(item_s1.operand_a) + 64'(item_s1.operand_b);
			ACT_SUB:      wide = 64'(item_s1.operand_a) - 64'(item_s1.operand_b);
			ACT_MUL:      wide = neg ? -$signed(mmag) : $signed(mmag);
			ACT_DIV: begin
				if (item_s1.div_zero) begin
					wide = item_s1.operand_a[DATA_W-1] ? SAT_LO : SAT_HI;
				end else begin
					wide = neg ? -$signed(qmag) : $signed(qmag);
				end
			end
			ACT_MIN:      wide = item_s1.less ? 64'(item_s1.operand_a) : 64'(item_s1.operand_b);
			ACT_MAX:      wide = item_s1.greater ? 64'(item_s1.operand_a) : 64'(item_s1.operand_b);
			ACT_INC:      wide = 64'(item_s1.operand_a) + 64'sd1;
			ACT_DEC:      wide = 64'(item_s1.operand_a) - 64'sd1;
			ACT_TO_INT: begin
				sat_en = 1'b0;
				wide = (64'(item_s1.operand_a)
					+ (item_s1.operand_a[DATA_W-1] ? TRUNC_ADJ : 64'sd0)) >>> FRAC_BITS;
			end
			ACT_FROM_INT: wide = 64'(item_s1.operand_a) <<< FRAC_BITS;
			default: begin
				wide = '0;
				sat_en = 1'b0;
			end
		endcase
		sat_val = wide;
		ovf = 1'b0;
		if (sat_en && wide > SAT_HI) begin
			sat_val = SAT_HI;
			ovf = 1'b1;
		end else if (sat_en && wide < SAT_LO) begin
			sat_val = SAT_LO;
			ovf = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= 1'b1;
			end else if (go_s1) begin
				v_s1 <= 1'b0;
			end
			if (go_s1) begin
				v_s2 <= 1'b1;
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= head_item;
			prod_s1 <= 64'(magnitude(head_item.operand_a)) * 64'(magnitude(head_item.operand_b));
		end
		if (go_s1) begin
			result_s2 <= sat_val[DATA_W-1:0];
			less_s2 <= item_s1.less;
			equal_s2 <= item_s1.equal;
			greater_s2 <= item_s1.greater;
			ovf_s2 <= ovf && !item_s1.div_zero;
			dz_s2 <= item_s1.div_zero;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata = {3'b000, dz_s2, ovf_s2, greater_s2, equal_s2, less_s2, result_s2};

	`FPA_ASSERT_NEVER(a_dz_no_ovf, v_s2 && dz_s2 && ovf_s2, "overflow raised with divide by zero")
	`FPA_ASSERT_IMPL(a_one_flag, v_s2, $onehot({less_s2, equal_s2, greater_s2}), "compare flags not one-hot")
	`FPA_ASSERT_IMPL(a_div_owner, div_busy, v_s1 && item_s1.action == ACT_DIV, "divider busy without a divide in stage 1")

endmodule

// File: sv/fixed_point_alu_top.sv
// Channel | Direction | Handshake          | Payload (lowest bit first)
// s_      | in        | s_tvalid, s_tready | action[3:0], operand_a[35:4], operand_b[67:36]
// m_      | out       | m_tvalid, m_tready | result[31:0], less, equal, greater, overflow,
//         |           |                    | divide_by_zero[36], zero fill to 40 bits
//
// One beat per cycle is accepted while the four-entry queue has room.
// Results pass from the queue head through the execute stage and then the output register; only divide waits there.
// Divide holds the execute stage until the bit-serial divider is done.
// Reset is asynchronous and empties the queue and both stages; there is no clearing pass.
// Output stalls back up through the queue into s_tready; results stay in order.
module fixed_point_alu_top
	import fpa_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // action, operand_a, operand_b
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // result, less, equal, greater, overflow, divide_by_zero
);

	item_t in_item, head_item;
	logic  full, head_valid, pop, push;

	assign s_tready = !full;
	assign push = s_tvalid && !full;

	fpa_front #(.WORD_WIDTH(WORD_WIDTH)) u_front (
		.tdata(s_tdata), .item(in_item)
	);

	fpa_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(in_item), .full(full),
		.pop(pop), .head_valid(head_valid), .head_item(head_item)
	);

	fpa_back #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(WORD_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .head_valid(head_valid), .head_item(head_item),
		.pop(pop), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule
